>>> hw/rtl/ffha_pkg.sv
// -----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and transaction types of the first-fit heap allocator.
// -----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 10;

  localparam int ADDR_W       = 32;
  localparam int REQ_W        = 12;
  localparam int POOL_BYTES_W = 13;

  localparam logic [POOL_BYTES_W-1:0] POOL_BYTES_RST = 13'd4096;
  localparam logic [ADDR_W-1:0]       POOL_BASE_RST  = 32'd0;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    REG_POOL_BASE  = 1'b0,
    REG_POOL_BYTES = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] free_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              status;
  } out_t;

  typedef struct packed {
    logic [0:0]        index;
    logic [ADDR_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       pool_base;
    logic [POOL_BYTES_W-1:0] pool_bytes;
  } cfg_regs_t;

endpackage

>>> hw/rtl/ffha_stream_if.sv
// -----------------------------------------------------------------------------
// ffha_stream_if
// Valid/ready channel carrying one payload per transaction.
// -----------------------------------------------------------------------------
interface ffha_stream_if #(
  parameter type T = logic [0:0]
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/first_fit_heap_allocator_top.sv
// -----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// One transaction is processed at a time; the header RAM read-then-write sequence
// sets the pace. A new transaction is accepted in idle while a result may still wait.
// Reset clears control state and config (pool_base 0, pool_bytes 4096); header
// RAM is not cleared and needs an init transaction before any allocate or free.
// -----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffha_stream_if.sink   in_i,
  ffha_stream_if.source out_o,
  ffha_stream_if.sink   cfg_i
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int DW = 2 * AW + 3;

  ffha_pkg::cfg_regs_t cfg_q, cfg_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        ffha_pkg::REG_POOL_BASE:  cfg_d.pool_base  = cfg_i.data.data;
        ffha_pkg::REG_POOL_BYTES: cfg_d.pool_bytes = cfg_i.data.data[ffha_pkg::POOL_BYTES_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base  <= ffha_pkg::POOL_BASE_RST;
      cfg_q.pool_bytes <= ffha_pkg::POOL_BYTES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  ffha_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ffha_ram #(
    .WIDTH (DW),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> hw/rtl/ffha_ram.sv
// -----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ffha_seq.sv
// -----------------------------------------------------------------------------
// ffha_seq
// Header walk and update sequencer: read, modify and write back block headers.
// -----------------------------------------------------------------------------
module ffha_seq #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ffha_pkg::cfg_regs_t              cfg_i,
  ffha_stream_if.sink                      in_i,
  ffha_stream_if.source                    out_o,
  output logic                             mem_we_o,
  output logic [$clog2(HEAP_BYTES)-1:0]    mem_waddr_o,
  output logic [2*$clog2(HEAP_BYTES)+2:0]  mem_wdata_o,
  output logic                             mem_re_o,
  output logic [$clog2(HEAP_BYTES)-1:0]    mem_raddr_o,
  input  logic [2*$clog2(HEAP_BYTES)+2:0]  mem_rdata_i
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW + 1;
  localparam int OW = AW + 2;
  localparam int PW = AW + 1;
  localparam int LW = (AW + 1 > ffha_pkg::POOL_BYTES_W) ? AW + 1 : ffha_pkg::POOL_BYTES_W;
  localparam int CW = (SW > ffha_pkg::REQ_W) ? SW : ffha_pkg::REQ_W;

  localparam logic [OW-1:0] HDR_O = OW'(HEADER_BYTES);
  localparam logic [SW-1:0] HDR_S = SW'(HEADER_BYTES);
  localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_RD   = 4'd1;
  localparam logic [3:0] S_A_CHK  = 4'd2;
  localparam logic [3:0] S_A_REST = 4'd3;
  localparam logic [3:0] S_LK_RD  = 4'd4;
  localparam logic [3:0] S_LK_WR  = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_E    = 4'd7;
  localparam logic [3:0] S_F_NRD  = 4'd8;
  localparam logic [3:0] S_F_N    = 4'd9;
  localparam logic [3:0] S_F_ERD  = 4'd10;
  localparam logic [3:0] S_F_E2   = 4'd11;
  localparam logic [3:0] S_F_P    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  typedef struct packed {
    logic [AW-1:0] prev;
    logic          first;
    logic [SW-1:0] size;
    logic          free;
  } hdr_t;

  logic [3:0]                  state_q, state_d;
  logic [3:0]                  ret_q, ret_d;
  logic [ffha_pkg::REQ_W-1:0]  req_q, req_d;
  logic [PW-1:0]               plen_q, plen_d;
  logic [OW-1:0]               at_q, at_d;
  logic [AW-1:0]               off_q, off_d;
  logic [AW-1:0]               prev_q, prev_d;
  hdr_t                        e_q, e_d;
  logic [OW-1:0]               lk_addr_q, lk_addr_d;
  logic [AW-1:0]               lk_val_q, lk_val_d;
  logic [ffha_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic                        status_q, status_d;
  logic                        out_valid_q, out_valid_d;
  ffha_pkg::out_t              out_q, out_d;

  logic [LW-1:0]               bytes_ext;
  logic [PW-1:0]               plen;
  logic [ffha_pkg::ADDR_W-1:0] foff;
  hdr_t                        rd;
  hdr_t                        nh;
  logic                        in_ready;
  logic                        fits;
  logic                        split;
  logic [OW-1:0]               rest;
  logic [OW-1:0]               nx;

  assign bytes_ext = LW'(cfg_i.pool_bytes);
  assign plen      = (bytes_ext < LW'(HEAP_BYTES)) ? PW'(bytes_ext) : PW'(HEAP_BYTES);
  assign foff      = in_i.data.free_address - cfg_i.pool_base
                     - ffha_pkg::ADDR_W'(HEADER_BYTES);
  assign rd        = hdr_t'(mem_rdata_i);
  assign fits      = rd.free && (CW'(rd.size) >= CW'(req_q));
  assign split     = (CW'(rd.size) - CW'(req_q)) > HDR_C;
  assign rest      = at_q + HDR_O + OW'(req_q);
  assign nx        = OW'(off_q) + HDR_O + OW'(rd.size);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    req_d       = req_q;
    plen_d      = plen_q;
    at_d        = at_q;
    off_d       = off_q;
    prev_d      = prev_q;
    e_d         = e_q;
    lk_addr_d   = lk_addr_q;
    lk_val_d    = lk_val_q;
    addr_d      = addr_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready    = 1'b0;
    nh          = rd;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          req_d    = in_i.data.request_size;
          plen_d   = plen;
          addr_d   = '0;
          status_d = 1'b0;
          case (in_i.data.opcode)
            ffha_pkg::OP_INIT: begin
              nh.prev  = '0;
              nh.first = 1'b1;
              if (OW'(plen) >= HDR_O) begin
                nh.size = SW'(OW'(plen) - HDR_O);
                nh.free = 1'b1;
              end else begin
                nh.size = '0;
                nh.free = 1'b0;
              end
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = nh;
              state_d     = S_DONE;
            end
            ffha_pkg::OP_ALLOC: begin
              at_d    = '0;
              state_d = S_A_RD;
            end
            ffha_pkg::OP_FREE: begin
              if (foff < ffha_pkg::ADDR_W'(plen)) begin
                off_d   = foff[AW-1:0];
                state_d = S_F_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_A_RD: begin
        if (at_q < OW'(plen_q)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = at_q[AW-1:0];
          state_d     = S_A_CHK;
        end else begin
          status_d = 1'b1;
          addr_d   = '0;
          state_d  = S_DONE;
        end
      end

      S_A_CHK: begin
        if (fits) begin
          nh.free = 1'b0;
          if (split) begin
            nh.size = SW'(req_q);
          end
          mem_we_o    = 1'b1;
          mem_waddr_o = at_q[AW-1:0];
          mem_wdata_o = nh;
          addr_d      = cfg_i.pool_base + ffha_pkg::ADDR_W'(at_q)
                        + ffha_pkg::ADDR_W'(HEADER_BYTES);
          e_d.prev    = at_q[AW-1:0];
          e_d.first   = 1'b0;
          e_d.size    = rd.size - SW'(req_q) - HDR_S;
          e_d.free    = 1'b1;
          lk_addr_d   = at_q + HDR_O + OW'(rd.size);
          lk_val_d    = rest[AW-1:0];
          ret_d       = S_DONE;
          state_d     = (split && (rest < OW'(plen_q))) ? S_A_REST : S_DONE;
        end else begin
          at_d    = at_q + HDR_O + OW'(rd.size);
          state_d = S_A_RD;
        end
      end

      S_A_REST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lk_val_q;
        mem_wdata_o = e_q;
        state_d     = S_LK_RD;
      end

      S_LK_RD: begin
        if (lk_addr_q < OW'(plen_q)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = lk_addr_q[AW-1:0];
          state_d     = S_LK_WR;
        end else begin
          state_d = ret_q;
        end
      end

      S_LK_WR: begin
        nh.prev     = lk_val_q;
        mem_we_o    = 1'b1;
        mem_waddr_o = lk_addr_q[AW-1:0];
        mem_wdata_o = nh;
        state_d     = ret_q;
      end

      S_F_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = off_q;
        state_d     = S_F_E;
      end

      S_F_E: begin
        nh.free     = 1'b1;
        mem_we_o    = 1'b1;
        mem_waddr_o = off_q;
        mem_wdata_o = nh;
        e_d         = nh;
        at_d        = nx;
        state_d     = (nx < OW'(plen_q)) ? S_F_NRD : S_F_ERD;
      end

      S_F_NRD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = at_q[AW-1:0];
        state_d     = S_F_N;
      end

      S_F_N: begin
        if (rd.free) begin
          nh          = e_q;
          nh.size     = e_q.size + HDR_S + rd.size;
          mem_we_o    = 1'b1;
          mem_waddr_o = off_q;
          mem_wdata_o = nh;
          lk_addr_d   = at_q + HDR_O + OW'(rd.size);
          lk_val_d    = off_q;
          ret_d       = S_F_ERD;
          state_d     = S_LK_RD;
        end else begin
          state_d = S_F_ERD;
        end
      end

      S_F_ERD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = off_q;
        state_d     = S_F_E2;
      end

      S_F_E2: begin
        if (!rd.first && (PW'(rd.prev) < plen_q)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd.prev;
          prev_d      = rd.prev;
          e_d         = rd;
          state_d     = S_F_P;
        end else begin
          state_d = S_DONE;
        end
      end

      S_F_P: begin
        if (rd.free) begin
          nh.size     = rd.size + HDR_S + e_q.size;
          mem_we_o    = 1'b1;
          mem_waddr_o = prev_q;
          mem_wdata_o = nh;
          lk_addr_d   = OW'(off_q) + HDR_O + OW'(e_q.size);
          lk_val_d    = prev_q;
          ret_d       = S_DONE;
          state_d     = S_LK_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.block_address = addr_q;
          out_d.status        = status_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    plen_q    <= plen_d;
    at_q      <= at_d;
    off_q     <= off_d;
    prev_q    <= prev_d;
    e_q       <= e_d;
    lk_addr_q <= lk_addr_d;
    lk_val_q  <= lk_val_d;
    addr_q    <= addr_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> hw/rtl/ffha_checker.sv
// -----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// -----------------------------------------------------------------------------
module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input ffha_pkg::out_t out_data_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + 2'(in_acc) - 2'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status |-> out_data_i.block_address == '0)
    else $error("failed allocate with nonzero address");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != 2'd0)
    else $error("result without a pending transaction");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q != 2'd2)
    else $error("transaction accepted with two results outstanding");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
